/* sv/pi_phase_controller_with_ramp_macros.svh */
// assertion macros for the pi phase controller block
`ifndef PI_PHASE_CONTROLLER_WITH_RAMP_MACROS_SVH
`define PI_PHASE_CONTROLLER_WITH_RAMP_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define PIPCR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// implication checked on every rising clock edge outside reset
`define PIPCR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define PIPCR_ASSERT(lbl, clk, rstn, prop, msg)
`define PIPCR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* sv/pipcr_pkg.sv */
// shared types and constants of the pi phase controller
`default_nettype none

package pipcr_pkg;

  localparam int ADC_W   = 12;
  localparam int GAIN_W  = 16;
  localparam int PHASE_W = 15;
  localparam int INTEG_W = 16;
  localparam int PC_W    = 16;
  localparam int ERR_W   = ADC_W + 1;
  localparam int MAG_W   = ADC_W + GAIN_W;
  localparam int QUOT_W  = 25;
  localparam int RECIP_W = 32;
  localparam int RECIP_SHIFT = 35;
  localparam int SUM_W   = 27;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  // reciprocal of ten, exact with the shift above for any 32-bit magnitude
  localparam logic [RECIP_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

  localparam logic signed [SUM_W-1:0] INTEG_LIMIT = 27'sd21888;
  localparam logic signed [SUM_W-1:0] PHASE_MAX   = 27'sd25000;
  localparam logic signed [SUM_W-1:0] PHASE_MIN   = 27'sd16;
  localparam logic signed [ERR_W-1:0] LOCK_ERR    = 13'sd5;
  localparam logic signed [ERR_W-1:0] GATE_ERR    = 13'sd10;

  localparam logic [PC_W-1:0]   PC_RESET         = 16'd16;
  localparam logic [ADC_W-1:0]  TARGET_RESET     = 12'd2400;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RESET  = 16'd100;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RESET = 16'd1;
  localparam logic [PC_W-1:0]   RAMP_LIMIT_RESET = 16'd17000;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_CLOSED = 2'd1,
    MODE_GATED  = 2'd2,
    MODE_FREE   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET     = 3'd0,
    CFG_PROP_GAIN  = 3'd1,
    CFG_INTEG_GAIN = 3'd2,
    CFG_RAMP_LIMIT = 3'd3,
    CFG_START_MODE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [ADC_W-1:0]  target_level;
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [PC_W-1:0]   ramp_limit;
  } cfg_t;

  typedef struct packed {
    logic  load;
    mode_e mode;
  } mode_ld_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic                    neg;
    logic [MAG_W-1:0]        prop_mag;
    logic [MAG_W-1:0]        integ_mag;
  } prod_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [QUOT_W:0]   prop;
    logic signed [QUOT_W:0]   integ_inc;
  } quot_t;

  typedef struct packed {
    logic [INTEG_W-1:0] integral;
    mode_e              mode;
    logic [PHASE_W-1:0] phase;
  } res_t;

endpackage

`default_nettype wire

/* sv/pipcr_prod.sv */
// error and gain product stage of the pi phase controller
`default_nettype none

module pipcr_prod (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [pipcr_pkg::ADC_W-1:0]       adc_i,
  input  pipcr_pkg::cfg_t                   cfg_i,
  output logic                              valid_o,
  output pipcr_pkg::prod_t                  prod_o
);
  import pipcr_pkg::*;

  logic signed [ERR_W-1:0] err;
  logic [ADC_W-1:0]        err_mag;
  prod_t                   prod_d, prod_q;
  logic                    valid_q;

  always_comb begin
    err = $signed({1'b0, cfg_i.target_level}) - $signed({1'b0, adc_i});
    err_mag = err[ERR_W-1] ? ADC_W'(-err) : err[ADC_W-1:0];
    prod_d.err       = err;
    prod_d.neg       = err[ERR_W-1];
    prod_d.prop_mag  = MAG_W'(cfg_i.prop_gain) * MAG_W'(err_mag);
    prod_d.integ_mag = MAG_W'(cfg_i.integ_gain) * MAG_W'(err_mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

`default_nettype wire

/* sv/pipcr_div.sv */
// divide-by-ten stage with truncation toward zero
`default_nettype none

module pipcr_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  pipcr_pkg::prod_t  prod_i,
  output logic              valid_o,
  output pipcr_pkg::quot_t  quot_o
);
  import pipcr_pkg::*;

  localparam int FULL_W = MAG_W + RECIP_W;

  logic [FULL_W-1:0] prop_full, integ_full;
  logic [QUOT_W-1:0] prop_div, integ_div;
  quot_t             quot_d, quot_q;
  logic              valid_q;

  always_comb begin
    prop_full  = FULL_W'(prod_i.prop_mag) * FULL_W'(RECIP_TEN);
    integ_full = FULL_W'(prod_i.integ_mag) * FULL_W'(RECIP_TEN);
    prop_div   = prop_full[RECIP_SHIFT +: QUOT_W];
    integ_div  = integ_full[RECIP_SHIFT +: QUOT_W];
    quot_d.err = prod_i.err;
    // magnitude quotient, sign put back afterwards
    quot_d.prop      = prod_i.neg ? -$signed({1'b0, prop_div})  : $signed({1'b0, prop_div});
    quot_d.integ_inc = prod_i.neg ? -$signed({1'b0, integ_div}) : $signed({1'b0, integ_div});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      quot_q <= quot_d;
    end
  end

  assign valid_o = valid_q;
  assign quot_o  = quot_q;

endmodule

`default_nettype wire

/* sv/pipcr_loop.sv */
// mode, ramp and integral state with the result register
`default_nettype none

module pipcr_loop (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  pipcr_pkg::quot_t    quot_i,
  input  pipcr_pkg::cfg_t     cfg_i,
  input  pipcr_pkg::mode_ld_t mode_ld_i,
  output logic                valid_o,
  output pipcr_pkg::res_t     res_o
);
  import pipcr_pkg::*;

  mode_e                      mode_q, mode_d;
  logic [PC_W-1:0]            pc_q, pc_d, pc_inc;
  logic signed [INTEG_W-1:0]  integ_q, integ_d, integ_base;
  logic [PHASE_W-1:0]         held_q, held_d;
  logic [PC_W-1:0]            hold_val;
  logic signed [SUM_W-1:0]    sum, integ_clamped, outv;
  logic                       ramp_en;
  logic                       valid_q;
  res_t                       res_q;
  logic                       step;

  assign step = en_i && valid_i;

  always_comb begin
    mode_d     = mode_q;
    pc_d       = pc_q;
    integ_base = integ_q;
    hold_val   = {1'b0, held_q};
    // start-up: count, lock onto the loop once the signed error is at most LOCK_ERR
    if (mode_q == MODE_START) begin
      pc_d       = pc_q + 16'd1;
      hold_val   = pc_q + 16'd1;
      integ_base = '0;
      if (quot_i.err <= LOCK_ERR) begin
        mode_d = MODE_CLOSED;
      end
    end
    pc_inc        = pc_d + 16'd1;
    sum           = SUM_W'(integ_base) + SUM_W'(quot_i.integ_inc);
    integ_clamped = SUM_W'(integ_base);
    outv          = $signed({11'b0, hold_val});
    integ_d       = integ_base;
    ramp_en       = 1'b0;
    unique case (mode_d)
      MODE_CLOSED: begin
        if (sum > INTEG_LIMIT) begin
          integ_clamped = INTEG_LIMIT;
        end else if (sum < -INTEG_LIMIT) begin
          integ_clamped = -INTEG_LIMIT;
        end else begin
          integ_clamped = sum;
        end
        integ_d = integ_clamped[INTEG_W-1:0];
        outv    = SUM_W'(quot_i.prop) + integ_clamped;
      end
      MODE_GATED: ramp_en = (quot_i.err <= GATE_ERR);
      MODE_FREE:  ramp_en = 1'b1;
      default:    ramp_en = 1'b0;
    endcase
    if (ramp_en && (pc_d < cfg_i.ramp_limit)) begin
      pc_d = pc_inc;
      outv = $signed({11'b0, pc_inc});
    end
    if (outv >= PHASE_MAX) begin
      held_d = PHASE_MAX[PHASE_W-1:0];
    end else if (outv < PHASE_MIN) begin
      held_d = PHASE_MIN[PHASE_W-1:0];
    end else begin
      held_d = outv[PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_START;
      pc_q    <= PC_RESET;
      integ_q <= '0;
      held_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (mode_ld_i.load) begin
        mode_q <= mode_ld_i.mode;
      end else if (step) begin
        mode_q <= mode_d;
      end
      if (step) begin
        pc_q    <= pc_d;
        integ_q <= integ_d;
        held_q  <= held_d;
      end
      if (en_i) begin
        valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q.phase    <= held_d;
      res_q.mode     <= mode_d;
      res_q.integral <= integ_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

/* sv/pi_phase_controller_with_ramp.sv */
// top level of the pi phase controller with start-up and ramp modes
//
//  channel   direction  transaction content
//  s_axis    in         adc sample, one per control period
//  m_axis    out        phase command, mode and integral after the step
//  cfg       in         register write, index and data, no read-back
//
// one transaction a cycle sustained unless m_axis_tready stalls; a sample passes the
// input register, gain multipliers, reciprocal multipliers for the division by
// ten, then the state update into the result register
// each stage holds only while it is full and the stage after it is held,
// so bubbles close up and input is taken while a result waits
// reset clears valid bits, integral and held phase, loads configuration and counter defaults, mode to start-up
`default_nettype none

`include "pi_phase_controller_with_ramp_macros.svh"

module pi_phase_controller_with_ramp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [pipcr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pipcr_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // sample input
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [pipcr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [11:0] adc_sample
  // result output
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [14:0] phase_out, [16:15] mode_out, [32:17] integral_out
  output logic [pipcr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import pipcr_pkg::*;

  cfg_t             cfg_q;
  mode_ld_t         mode_ld;
  logic             in_v_q;
  logic [ADC_W-1:0] adc_q;
  logic             prod_v, quot_v, res_v;
  prod_t            prod;
  quot_t            quot;
  res_t             res;
  logic             en_in, en_prod, en_quot, en_res;

  // stage enables, from the output back
  assign en_res  = !res_v  || m_axis_tready;
  assign en_quot = !quot_v || en_res;
  assign en_prod = !prod_v || en_quot;
  assign en_in   = !in_v_q || en_prod;

  assign s_axis_tready = en_in;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_level <= TARGET_RESET;
      cfg_q.prop_gain    <= PROP_GAIN_RESET;
      cfg_q.integ_gain   <= INTEG_GAIN_RESET;
      cfg_q.ramp_limit   <= RAMP_LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGET:     cfg_q.target_level <= cfg_wdata_i[ADC_W-1:0];
        CFG_PROP_GAIN:  cfg_q.prop_gain    <= cfg_wdata_i[GAIN_W-1:0];
        CFG_INTEG_GAIN: cfg_q.integ_gain   <= cfg_wdata_i[GAIN_W-1:0];
        CFG_RAMP_LIMIT: cfg_q.ramp_limit   <= cfg_wdata_i[PC_W-1:0];
        default:        ;
      endcase
    end
  end

  // start mode has no register of its own beyond the live mode it loads
  assign mode_ld.load = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_START_MODE);
  assign mode_ld.mode = mode_e'(cfg_wdata_i[1:0]);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en_in) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_in && s_axis_tvalid) begin
      adc_q <= s_axis_tdata[ADC_W-1:0];
    end
  end

  pipcr_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_prod),
    .valid_i (in_v_q),
    .adc_i   (adc_q),
    .cfg_i   (cfg_q),
    .valid_o (prod_v),
    .prod_o  (prod)
  );

  pipcr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_quot),
    .valid_i (prod_v),
    .prod_i  (prod),
    .valid_o (quot_v),
    .quot_o  (quot)
  );

  pipcr_loop u_loop (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en_res),
    .valid_i   (quot_v),
    .quot_i    (quot),
    .cfg_i     (cfg_q),
    .mode_ld_i (mode_ld),
    .valid_o   (res_v),
    .res_o     (res)
  );

  assign m_axis_tvalid = res_v;
  assign m_axis_tdata  = OUT_TDATA_W'(res);

  // phase command always inside the clamp window
  `PIPCR_ASSERT_IMP(a_phase_range, clk_i, rst_ni, m_axis_tvalid,
                    (res.phase >= 15'd16) && (res.phase <= 15'd25000), "phase out of range")
  // integral always inside its clamp
  `PIPCR_ASSERT_IMP(a_integ_range, clk_i, rst_ni, m_axis_tvalid,
                    ($signed(res.integral) <= 16'sd21888) &&
                    ($signed(res.integral) >= -16'sd21888), "integral out of range")
  // start-up keeps the integral cleared
  `PIPCR_ASSERT_IMP(a_start_integ, clk_i, rst_ni, m_axis_tvalid && (res.mode == MODE_START),
                    res.integral == '0, "integral not cleared in start-up")
  // an empty result register never blocks the input
  `PIPCR_ASSERT_IMP(a_ready_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready,
                    "input blocked with empty output")

endmodule

`default_nettype wire
